@@ hw/rtl/pca_pkg.sv @@
// Shared types and constants of the pixel colour adjustment pipeline.
package pca_pkg;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 15;
    localparam int AMT_W      = 14;
    localparam int MUL_W      = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int REG_FRAC   = 12;
    localparam int NSTAGE     = 7;

    localparam logic [GAIN_W-1:0]       GAIN_RESET = GAIN_W'(1) << REG_FRAC;
    localparam logic signed [MUL_W-1:0] MUL_UNITY  = MUL_W'(1) <<< REG_FRAC;

    localparam int LUMA_R_COEF = 1225;
    localparam int LUMA_G_COEF = 2404;
    localparam int LUMA_B_COEF = 467;

    localparam logic [10:0] TEMP_C_HI  = 11'd1229;
    localparam logic [10:0] TEMP_C_MID = 11'd819;
    localparam logic [10:0] TEMP_C_LO  = 11'd410;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPOSURE    = 3'd0,
        CFG_CONTRAST    = 3'd1,
        CFG_BRIGHTNESS  = 3'd2,
        CFG_SATURATION  = 3'd3,
        CFG_TEMPERATURE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [NSTAGE-1:0] load;
    } t_pipe_ctl;

endpackage

@@ hw/rtl/pca_in_if.sv @@
// Input pixel channel: valid, ready and one RGB word.
interface pca_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

@@ hw/rtl/pca_out_if.sv @@
// Output pixel channel: valid, ready and one adjusted RGB word.
interface pca_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

@@ hw/rtl/pca_cfg.sv @@
// Configuration registers and the per-setting multipliers and offsets derived from them.
module pca_cfg #(
    parameter int FRAC_BITS = 12
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]           i_idx,
    input  logic [pca_pkg::CFG_DATA_W-1:0]          i_data,
    output logic [pca_pkg::GAIN_W-1:0]              o_gain,
    output logic signed [pca_pkg::MUL_W-1:0]        o_cmul,
    output logic signed [pca_pkg::MUL_W-1:0]        o_smul,
    output logic signed [FRAC_BITS+4:0]             o_boff,
    output logic signed [FRAC_BITS+4:0]             o_dr,
    output logic signed [FRAC_BITS+4:0]             o_dg,
    output logic signed [FRAC_BITS+4:0]             o_db
);
    import pca_pkg::*;

    localparam int W = FRAC_BITS + 5;
    localparam int K = 2 * REG_FRAC - FRAC_BITS;

    logic [GAIN_W-1:0]         r_gain;
    logic signed [AMT_W-1:0]   r_contrast;
    logic signed [AMT_W-1:0]   r_bright;
    logic signed [AMT_W-1:0]   r_satur;
    logic signed [AMT_W-1:0]   r_temp;

    logic signed [MUL_W-1:0]   r_cmul, n_cmul;
    logic signed [MUL_W-1:0]   r_smul, n_smul;
    logic signed [W-1:0]       r_boff, n_boff;
    logic signed [W-1:0]       r_dr, n_dr;
    logic signed [W-1:0]       r_dg, n_dg;
    logic signed [W-1:0]       r_db, n_db;

    function automatic logic signed [W-1:0] temp_delta(
        input logic signed [AMT_W-1:0] t,
        input logic [10:0]             coef
    );
        logic signed [25:0] p;
        logic signed [26:0] w;
        p = t * signed'({1'b0, coef});
        w = 27'(p) + (27'(1) <<< (K - 1));
        return W'(w >>> K);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= GAIN_RESET;
            r_contrast <= '0;
            r_bright   <= '0;
            r_satur    <= '0;
            r_temp     <= '0;
        end else if (i_we) begin
            case (t_cfg_idx'(i_idx))
                CFG_EXPOSURE:    r_gain     <= i_data[GAIN_W-1:0];
                CFG_CONTRAST:    r_contrast <= signed'(i_data[AMT_W-1:0]);
                CFG_BRIGHTNESS:  r_bright   <= signed'(i_data[AMT_W-1:0]);
                CFG_SATURATION:  r_satur    <= signed'(i_data[AMT_W-1:0]);
                CFG_TEMPERATURE: r_temp     <= signed'(i_data[AMT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    generate
        if (FRAC_BITS >= REG_FRAC) begin : g_boff_up
            assign n_boff = W'(r_bright) <<< (FRAC_BITS - REG_FRAC);
        end else begin : g_boff_dn
            logic signed [AMT_W:0] bw;
            assign bw     = (AMT_W+1)'(r_bright) + ((AMT_W+1)'(1) <<< (REG_FRAC - FRAC_BITS - 1));
            assign n_boff = W'(bw >>> (REG_FRAC - FRAC_BITS));
        end
    endgenerate

    always_comb begin
        n_cmul = MUL_UNITY + MUL_W'(r_contrast);
        n_smul = MUL_UNITY + MUL_W'(r_satur);
        n_dg   = temp_delta(r_temp, TEMP_C_LO);
        if (r_temp > 0) begin
            n_dr = temp_delta(r_temp, TEMP_C_HI);
            n_db = -temp_delta(r_temp, TEMP_C_MID);
        end else begin
            n_dr = temp_delta(r_temp, TEMP_C_MID);
            n_db = -temp_delta(r_temp, TEMP_C_HI);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmul <= MUL_UNITY;
            r_smul <= MUL_UNITY;
            r_boff <= '0;
            r_dr   <= '0;
            r_dg   <= '0;
            r_db   <= '0;
        end else begin
            r_cmul <= n_cmul;
            r_smul <= n_smul;
            r_boff <= n_boff;
            r_dr   <= n_dr;
            r_dg   <= n_dg;
            r_db   <= n_db;
        end
    end

    assign o_gain = r_gain;
    assign o_cmul = r_cmul;
    assign o_smul = r_smul;
    assign o_boff = r_boff;
    assign o_dr   = r_dr;
    assign o_dg   = r_dg;
    assign o_db   = r_db;

endmodule

@@ hw/rtl/pca_ctrl.sv @@
// Stage valid bits and the backward ready chain of the pipeline.
module pca_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output pca_pkg::t_pipe_ctl  o_ctl
);
    import pca_pkg::*;

    logic [NSTAGE-1:0] r_valid, n_valid;
    logic [NSTAGE:0]   adv;

    always_comb begin
        adv[NSTAGE] = i_out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
        n_valid[0] = adv[0] ? i_in_valid : r_valid[0];
        for (int k = 1; k < NSTAGE; k++) begin
            n_valid[k] = adv[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = adv[0];
    assign o_out_valid = r_valid[NSTAGE-1];
    assign o_ctl.load  = adv[NSTAGE-1:0];

endmodule

@@ hw/rtl/pca_datapath.sv @@
// Seven-stage colour arithmetic: convert, exposure, contrast, brightness, luma,
// saturation, temperature and output conversion.
module pca_datapath #(
    parameter int FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  pca_pkg::t_pipe_ctl                i_ctl,
    input  logic [pca_pkg::GAIN_W-1:0]        i_gain,
    input  logic signed [pca_pkg::MUL_W-1:0]  i_cmul,
    input  logic signed [pca_pkg::MUL_W-1:0]  i_smul,
    input  logic signed [FRAC_BITS+4:0]       i_boff,
    input  logic signed [FRAC_BITS+4:0]       i_dr,
    input  logic signed [FRAC_BITS+4:0]       i_dg,
    input  logic signed [FRAC_BITS+4:0]       i_db,
    input  logic [2:0][pca_pkg::PIX_W-1:0]    i_pix,
    output logic [2:0][pca_pkg::PIX_W-1:0]    o_pix
);
    import pca_pkg::*;

    localparam int W  = FRAC_BITS + 5;
    localparam int L  = W + 18;
    localparam int CW = FRAC_BITS + 1;

    typedef logic signed [W-1:0] t_fx;
    typedef logic signed [L-1:0] t_wide;
    typedef logic [CW-1:0]       t_conv_tab [256];

    localparam t_wide SAT_L  = t_wide'(1) <<< (FRAC_BITS + 3);
    localparam t_wide ONE_L  = t_wide'(1) <<< FRAC_BITS;
    localparam t_wide RND_L  = t_wide'(1) <<< (REG_FRAC - 1);
    localparam t_wide LUMA_R = t_wide'(LUMA_R_COEF);
    localparam t_wide LUMA_G = t_wide'(LUMA_G_COEF);
    localparam t_wide LUMA_B = t_wide'(LUMA_B_COEF);
    localparam logic signed [W:0] HALF_D = (W+1)'(1) <<< (FRAC_BITS - 1);

    function automatic t_conv_tab conv_tab();
        t_conv_tab t;
        for (int c = 0; c < 256; c++) begin
            t[c] = CW'((2 * c * (1 << FRAC_BITS) + 255) / 510);
        end
        return t;
    endfunction

    localparam t_conv_tab CONV = conv_tab();

    function automatic t_wide rnd_reg(input t_wide v);
        t_wide w;
        w = v + RND_L;
        return w >>> REG_FRAC;
    endfunction

    function automatic t_fx sat_fx(input t_wide v);
        t_wide s;
        if (v > SAT_L) begin
            s = SAT_L;
        end else if (v < -SAT_L) begin
            s = -SAT_L;
        end else begin
            s = v;
        end
        return t_fx'(s);
    endfunction

    logic [CW-1:0]           r_s0 [3];
    logic [CW-1:0]           n_s0 [3];
    t_fx                     r_s1 [3];
    t_fx                     n_s1 [3];
    t_fx                     r_s2 [3];
    t_fx                     n_s2 [3];
    t_fx                     r_s3 [3];
    t_fx                     n_s3 [3];
    t_fx                     r_s4 [3];
    t_fx                     r_s5 [3];
    t_fx                     n_s5 [3];
    t_fx                     r_luma, n_luma;
    t_fx                     delta [3];
    logic [2:0][PIX_W-1:0]   r_out, n_out;

    always_comb begin
        logic signed [CW:0]        x0;
        logic signed [GAIN_W:0]    g;
        logic signed [CW+GAIN_W:0] pe;
        logic signed [W:0]         dc;
        logic signed [W+MUL_W:0]   pc;
        logic signed [W:0]         ds;
        logic signed [W+MUL_W:0]   ps;
        t_wide                     acc;
        t_wide                     y;
        t_wide                     y255;

        g        = signed'({1'b0, i_gain});
        delta[0] = i_dr;
        delta[1] = i_dg;
        delta[2] = i_db;

        acc    = t_wide'(r_s3[0]) * LUMA_R + t_wide'(r_s3[1]) * LUMA_G
               + t_wide'(r_s3[2]) * LUMA_B;
        n_luma = t_fx'(rnd_reg(acc));

        for (int c = 0; c < 3; c++) begin
            n_s0[c] = CONV[i_pix[c]];

            x0      = signed'({1'b0, r_s0[c]});
            pe      = x0 * g;
            n_s1[c] = sat_fx(rnd_reg(t_wide'(pe)));

            dc      = (W+1)'(r_s1[c]) - HALF_D;
            pc      = dc * i_cmul;
            n_s2[c] = sat_fx(rnd_reg(t_wide'(pc)) + t_wide'(HALF_D));

            n_s3[c] = sat_fx(t_wide'(r_s2[c]) + t_wide'(i_boff));

            ds      = (W+1)'(r_s4[c]) - (W+1)'(r_luma);
            ps      = ds * i_smul;
            n_s5[c] = sat_fx(t_wide'(r_luma) + rnd_reg(t_wide'(ps)));

            y = t_wide'(r_s5[c]) + t_wide'(delta[c]);
            if (y < 0) begin
                y = '0;
            end else if (y > ONE_L) begin
                y = ONE_L;
            end
            y255     = (y <<< 8) - y;
            n_out[c] = PIX_W'(y255 >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) r_s0 <= n_s0;
        if (i_ctl.load[1]) r_s1 <= n_s1;
        if (i_ctl.load[2]) r_s2 <= n_s2;
        if (i_ctl.load[3]) r_s3 <= n_s3;
        if (i_ctl.load[4]) begin
            r_s4   <= r_s3;
            r_luma <= n_luma;
        end
        if (i_ctl.load[5]) r_s5  <= n_s5;
        if (i_ctl.load[6]) r_out <= n_out;
    end

    assign o_pix = r_out;

endmodule

@@ hw/rtl/pixel_color_adjust_pipeline_core.sv @@
// Top level of the pixel colour adjustment pipeline.
//
// Pixels enter on i_pix and leave on o_pix; a word moves on a rising edge at
// which valid and ready are both high. Each word is one RGB pixel of three
// 8-bit channels. The configuration port writes register i_cfg_idx with
// i_cfg_data on an edge with i_cfg_we high: 0 exposure gain, 1 contrast,
// 2 brightness, 3 saturation, 4 temperature; other indexes are dropped.
// Write settings only while no pixel is in flight.
// Throughput: one pixel per clock while the receiver is ready, from seven
// register stages with one multiply per channel in the exposure, contrast
// and saturation stages and the luma sum in a stage of its own.
// Reset clears every stage valid bit and returns the settings to neutral
// (gain 1.0, all amounts zero). When the receiver stalls, the output word
// holds and stages behind it keep filling bubbles; i_pix.ready drops only
// once every stage holds a word.
module pixel_color_adjust_pipeline_core #(
    parameter int FRAC_BITS = 12
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pca_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    pca_in_if.sink                             i_pix,
    pca_out_if.source                          o_pix
);
    import pca_pkg::*;

    localparam int W = FRAC_BITS + 5;

    logic                    in_valid;
    logic                    in_ready;
    logic                    out_valid;
    logic                    out_ready;
    logic [2:0][PIX_W-1:0]   in_data;
    logic [2:0][PIX_W-1:0]   out_data;
    t_pipe_ctl               ctl;

    logic [GAIN_W-1:0]       gain;
    logic signed [MUL_W-1:0] cmul;
    logic signed [MUL_W-1:0] smul;
    logic signed [W-1:0]     boff;
    logic signed [W-1:0]     dr;
    logic signed [W-1:0]     dg;
    logic signed [W-1:0]     db;

    assign in_valid    = i_pix.valid;
    assign i_pix.ready = in_ready;
    assign in_data[0]  = i_pix.red_in;
    assign in_data[1]  = i_pix.green_in;
    assign in_data[2]  = i_pix.blue_in;

    assign out_ready       = o_pix.ready;
    assign o_pix.valid     = out_valid;
    assign o_pix.red_out   = out_data[0];
    assign o_pix.green_out = out_data[1];
    assign o_pix.blue_out  = out_data[2];

    pca_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_gain  (gain),
        .o_cmul  (cmul),
        .o_smul  (smul),
        .o_boff  (boff),
        .o_dr    (dr),
        .o_dg    (dg),
        .o_db    (db)
    );

    pca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_out_ready (out_ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    pca_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_gain (gain),
        .i_cmul (cmul),
        .i_smul (smul),
        .i_boff (boff),
        .i_dr   (dr),
        .i_dg   (dg),
        .i_db   (db),
        .i_pix  (in_data),
        .o_pix  (out_data)
    );

endmodule

@@ hw/rtl/pca_checker.sv @@
// Port-level checks of the pixel colour adjustment pipeline and their binding.
module pca_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [2:0][pca_pkg::PIX_W-1:0]   i_out_data
);
    import pca_pkg::*;

    localparam int CNT_W = $clog2(NSTAGE + 2);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             in_acc;
    logic             out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_acc && !out_acc) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (out_acc && !in_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled output word changed");

    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input blocked while the receiver takes words");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("output word with no pixel in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NSTAGE))
        else $error("more pixels in flight than stages");

endmodule

bind pixel_color_adjust_pipeline_core pca_checker u_pca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (in_valid),
    .i_in_ready  (in_ready),
    .i_out_valid (out_valid),
    .i_out_ready (out_ready),
    .i_out_data  (out_data)
);

@@ tb/tb_top.sv @@
// Self-checking testbench of the pixel colour adjustment pipeline: random settings and pixels.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pca_pkg::*;

    localparam int     FRAC         = 12;
    localparam longint ONE          = longint'(1) << FRAC;
    localparam longint HALF         = ONE / 2;
    localparam longint SAT_LIMIT    = 8 * ONE;
    localparam longint UNITY        = longint'(1) << REG_FRAC;
    localparam int     TEMP_SHIFT   = 2 * REG_FRAC - FRAC;
    localparam int     RANDOM_WORDS = 400;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    bit                      clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_data;

    pca_in_if  pix_in ();
    pca_out_if pix_out ();

    pixel_color_adjust_pipeline_core #(
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    logic [GAIN_W-1:0]       gain_set;
    logic signed [AMT_W-1:0] contrast_set;
    logic signed [AMT_W-1:0] brightness_set;
    logic signed [AMT_W-1:0] saturation_set;
    logic signed [AMT_W-1:0] temperature_set;

    t_rgb pending_pixels[$];
    t_rgb adjusted_pixels[$];
    t_rgb next_word;
    t_rgb seen_word;
    t_rgb want_word;
    bit   holding_word;
    int   burst_left;
    int   gap_left;
    int   stall_mode;
    int   mode_left;
    int   mismatch_count;
    int   cycle_count;

    always #2 clk = ~clk;

    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint limit8(longint v);
        if (v > SAT_LIMIT)
            return SAT_LIMIT;
        if (v < -SAT_LIMIT)
            return -SAT_LIMIT;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] to_byte(longint v);
        longint c;
        c = (v < 0) ? 0 : ((v > ONE) ? ONE : v);
        return PIX_W'((c * 255) >>> FRAC);
    endfunction

    function automatic t_rgb adjust_pixel(t_rgb p);
        longint ch[3];
        longint delta[3];
        longint gain, cmul, boff, smul, temp, luma, x;
        t_rgb   q;
        ch[0] = (2 * longint'(p.red) * ONE + 255) / 510;
        ch[1] = (2 * longint'(p.green) * ONE + 255) / 510;
        ch[2] = (2 * longint'(p.blue) * ONE + 255) / 510;
        gain  = longint'(gain_set);
        cmul  = UNITY + longint'(contrast_set);
        boff  = longint'(brightness_set) << (FRAC - REG_FRAC);
        smul  = UNITY + longint'(saturation_set);
        temp  = longint'(temperature_set);
        for (int i = 0; i < 3; i++) begin
            x = limit8(round_shift(ch[i] * gain, REG_FRAC));
            x = limit8(round_shift((x - HALF) * cmul, REG_FRAC) + HALF);
            ch[i] = limit8(x + boff);
        end
        luma = round_shift(LUMA_R_COEF * ch[0] + LUMA_G_COEF * ch[1] + LUMA_B_COEF * ch[2], 12);
        for (int i = 0; i < 3; i++)
            ch[i] = limit8(luma + round_shift((ch[i] - luma) * smul, REG_FRAC));
        if (temp > 0) begin
            delta[0] = round_shift(temp * longint'(TEMP_C_HI), TEMP_SHIFT);
            delta[1] = round_shift(temp * longint'(TEMP_C_LO), TEMP_SHIFT);
            delta[2] = -round_shift(temp * longint'(TEMP_C_MID), TEMP_SHIFT);
        end else begin
            delta[0] = round_shift(temp * longint'(TEMP_C_MID), TEMP_SHIFT);
            delta[1] = round_shift(temp * longint'(TEMP_C_LO), TEMP_SHIFT);
            delta[2] = -round_shift(temp * longint'(TEMP_C_HI), TEMP_SHIFT);
        end
        for (int i = 0; i < 3; i++)
            ch[i] = limit8(ch[i] + delta[i]);
        q.red   = to_byte(ch[0]);
        q.green = to_byte(ch[1]);
        q.blue  = to_byte(ch[2]);
        return q;
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb p;
        logic [PIX_W-1:0] corner[6];
        corner = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
        case ($urandom_range(0, 9))
            0: p = '{corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
                     corner[$urandom_range(0, 5)]};
            1: begin
                p.red   = PIX_W'($urandom);
                p.green = p.red;
                p.blue  = p.red;
            end
            default: p = t_rgb'((3*PIX_W)'($urandom));
        endcase
        return p;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return GAIN_W'(1024);
            1: return GAIN_W'(16384);
            2: return GAIN_RESET;
            3: return '0;
            4: return '1;
            default: return GAIN_W'($urandom_range(1024, 16384));
        endcase
    endfunction

    function automatic logic signed [AMT_W-1:0] pick_amount();
        case ($urandom_range(0, 9))
            0: return -AMT_W'(4096);
            1: return AMT_W'(4096);
            2: return '0;
            3: return {1'b1, {(AMT_W-1){1'b0}}};
            4: return {1'b0, {(AMT_W-1){1'b1}}};
            default: return AMT_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
    endfunction

    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_EXPOSURE:    gain_set        = data;
            CFG_CONTRAST:    contrast_set    = data[AMT_W-1:0];
            CFG_BRIGHTNESS:  brightness_set  = data[AMT_W-1:0];
            CFG_SATURATION:  saturation_set  = data[AMT_W-1:0];
            CFG_TEMPERATURE: temperature_set = data[AMT_W-1:0];
            default: ;
        endcase
    endtask

    // the spare top bit of an amount write must be dropped by the block
    task automatic apply_settings(input logic [GAIN_W-1:0] g,
                                  input logic signed [AMT_W-1:0] c, b, s, t);
        write_setting(CFG_EXPOSURE, g);
        write_setting(CFG_CONTRAST, {1'($urandom_range(0, 1)), c});
        write_setting(CFG_BRIGHTNESS, {1'($urandom_range(0, 1)), b});
        write_setting(CFG_SATURATION, {1'($urandom_range(0, 1)), s});
        write_setting(CFG_TEMPERATURE, {1'($urandom_range(0, 1)), t});
        write_setting(CFG_IDX_W'(CFG_TEMPERATURE) + CFG_IDX_W'($urandom_range(1, 3)),
                      CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || holding_word || adjusted_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_in.valid <= 1'b0;
            holding_word = 1'b0;
            burst_left   = 1;
            gap_left     = 0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                seen_word = '{pix_in.red_in, pix_in.green_in, pix_in.blue_in};
                adjusted_pixels.push_back(adjust_pixel(seen_word));
                holding_word = 1'b0;
            end
            if (!holding_word) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pix_in.valid <= 1'b0;
                end else if (pending_pixels.size() != 0) begin
                    next_word = pending_pixels.pop_front();
                    pix_in.red_in   <= next_word.red;
                    pix_in.green_in <= next_word.green;
                    pix_in.blue_in  <= next_word.blue;
                    pix_in.valid    <= 1'b1;
                    holding_word = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        gap_left   = $urandom_range(1, 8);
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 24);
                    end
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each word, then stall on a changing pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            pix_out.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                if (adjusted_pixels.size() == 0) begin
                    $error("unexpected output word: %0d %0d %0d",
                           pix_out.red_out, pix_out.green_out, pix_out.blue_out);
                    mismatch_count++;
                end else begin
                    want_word = adjusted_pixels.pop_front();
                    check_field("red_out", want_word.red, pix_out.red_out);
                    check_field("green_out", want_word.green, pix_out.green_out);
                    check_field("blue_out", want_word.blue, pix_out.blue_out);
                end
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 64);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: pix_out.ready <= 1'b1;
                1: pix_out.ready <= 1'($urandom_range(0, 1));
                2: pix_out.ready <= ($urandom_range(0, 3) == 0);
                default: pix_out.ready <= mode_left[1];
            endcase
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** pixel_color_adjust_pipeline_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int   random_sent;
        int   phase;
        int   words;
        t_rgb directed[14];
        directed = '{
            '{8'd0, 8'd0, 8'd0},       '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
            '{8'd0, 8'd255, 8'd0},     '{8'd0, 8'd0, 8'd255},     '{8'd1, 8'd1, 8'd1},
            '{8'd254, 8'd254, 8'd254}, '{8'd128, 8'd128, 8'd128}, '{8'd127, 8'd127, 8'd127},
            '{8'hAA, 8'h55, 8'hAA},    '{8'h55, 8'hAA, 8'h55},    '{8'd0, 8'd128, 8'd255},
            '{8'd255, 8'd128, 8'd0},   '{8'd17, 8'd200, 8'd99}
        };
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        pix_in.valid    = 1'b0;
        pix_in.red_in   = '0;
        pix_in.green_in = '0;
        pix_in.blue_in  = '0;
        pix_out.ready   = 1'b0;
        gain_set        = GAIN_RESET;
        contrast_set    = '0;
        brightness_set  = '0;
        saturation_set  = '0;
        temperature_set = '0;
        mismatch_count  = 0;
        cycle_count     = 0;
        random_sent     = 0;
        phase           = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // neutral settings straight out of reset
        foreach (directed[i])
            pending_pixels.push_back(directed[i]);
        drain();

        while (random_sent < RANDOM_WORDS) begin
            case (phase)
                0: apply_settings(GAIN_W'(1024), -AMT_W'(4096), -AMT_W'(4096),
                                  -AMT_W'(4096), -AMT_W'(4096));
                1: apply_settings(GAIN_W'(16384), AMT_W'(4096), AMT_W'(4096),
                                  AMT_W'(4096), AMT_W'(4096));
                2: apply_settings('0, {1'b1, {(AMT_W-1){1'b0}}}, {1'b1, {(AMT_W-1){1'b0}}},
                                  {1'b1, {(AMT_W-1){1'b0}}}, {1'b1, {(AMT_W-1){1'b0}}});
                3: apply_settings('1, {1'b0, {(AMT_W-1){1'b1}}}, {1'b0, {(AMT_W-1){1'b1}}},
                                  {1'b0, {(AMT_W-1){1'b1}}}, {1'b0, {(AMT_W-1){1'b1}}});
                4: apply_settings(GAIN_RESET, '0, '0, '0, '0);
                default: apply_settings(pick_gain(), pick_amount(), pick_amount(),
                                        pick_amount(), pick_amount());
            endcase
            phase++;
            words = $urandom_range(15, 45);
            repeat (words)
                pending_pixels.push_back(random_pixel());
            random_sent += words;
            drain();
        end

        repeat (NSTAGE + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("** pixel_color_adjust_pipeline_core: PASSED **");
        else
            $display("** pixel_color_adjust_pipeline_core: FAILED **");
        $finish;
    end

endmodule
